@@ sv/dto_pkg.sv @@
`default_nettype none
package dto_pkg;

    localparam int DATA_W      = 32;
    localparam int BW_W        = 14;
    localparam int COEF_BITS   = 30;
    localparam int US_PER_S    = 1000000;
    localparam int PROD_W      = 66;
    localparam int DIV_W       = 50;
    localparam int DIV_STEPS   = DIV_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W   = 1;

    localparam int DEF_SAMPLE_PERIOD_US = 1000;
    localparam int DEF_FRAC_BITS        = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BANDWIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INERTIA   = 1'd1;

    localparam logic [BW_W-1:0]   BW_RESET      = 14'd100;
    localparam logic [DATA_W-1:0] INERTIA_RESET = 32'd65536;

    localparam logic [2:0] MUL_SQ  = 3'd0;
    localparam logic [2:0] MUL_TQ  = 3'd1;
    localparam logic [2:0] MUL_K1L = 3'd2;
    localparam logic [2:0] MUL_K2L = 3'd3;
    localparam logic [2:0] MUL_K3L = 3'd4;
    localparam logic [2:0] MUL_K1R = 3'd5;
    localparam logic [2:0] MUL_K2R = 3'd6;
    localparam logic [2:0] MUL_K3R = 3'd7;

    localparam logic [3:0] ACC_NONE = 4'd0;
    localparam logic [3:0] ACC_K    = 4'd1;
    localparam logic [3:0] ACC_TQ   = 4'd2;
    localparam logic [3:0] ACC_SET  = 4'd3;
    localparam logic [3:0] ACC_ADD  = 4'd4;
    localparam logic [3:0] ACC_SUB  = 4'd5;
    localparam logic [3:0] ACC_ZL   = 4'd6;
    localparam logic [3:0] ACC_ZR   = 4'd7;
    localparam logic [3:0] ACC_RES  = 4'd8;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic [2:0] mul_sel;
        logic [3:0] acc_op;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;

    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] value;
    } t_clip;

    function automatic t_clip clip32(input logic signed [PROD_W-1:0] v);
        t_clip r;
        logic signed [PROD_W-1:0] max_v;
        logic signed [PROD_W-1:0] min_v;
        max_v = {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        min_v = {{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
        if (v > max_v) begin
            r.sat   = 1'b1;
            r.value = max_v[DATA_W-1:0];
        end else if (v < min_v) begin
            r.sat   = 1'b1;
            r.value = min_v[DATA_W-1:0];
        end else begin
            r.sat   = 1'b0;
            r.value = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/dto_ctrl.sv @@
`default_nettype none
module dto_ctrl
    import dto_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    output logic         o_m_axis_tvalid,
    input  wire logic    i_m_axis_tready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_SQ   = 4'd2;
    localparam logic [3:0] S_KS   = 4'd3;
    localparam logic [3:0] S_TQ   = 4'd4;
    localparam logic [3:0] S_L1   = 4'd5;
    localparam logic [3:0] S_L2   = 4'd6;
    localparam logic [3:0] S_L3   = 4'd7;
    localparam logic [3:0] S_L4   = 4'd8;
    localparam logic [3:0] S_L5   = 4'd9;
    localparam logic [3:0] S_R1   = 4'd10;
    localparam logic [3:0] S_R2   = 4'd11;
    localparam logic [3:0] S_R3   = 4'd12;
    localparam logic [3:0] S_R4   = 4'd13;
    localparam logic [3:0] S_R5   = 4'd14;
    localparam logic [3:0] S_RES  = 4'd15;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_slot_free;

    assign w_slot_free     = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd.load     = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.mul_sel  = MUL_SQ;
        o_cmd.acc_op   = ACC_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.mul_sel = MUL_SQ;
                n_state       = S_KS;
            end
            S_KS: begin
                o_cmd.acc_op  = ACC_K;
                o_cmd.mul_sel = MUL_TQ;
                n_state       = S_TQ;
            end
            S_TQ: begin
                o_cmd.acc_op = ACC_TQ;
                n_state      = S_L1;
            end
            S_L1: begin
                o_cmd.mul_sel = MUL_K1L;
                n_state       = S_L2;
            end
            S_L2: begin
                o_cmd.acc_op  = ACC_SET;
                o_cmd.mul_sel = MUL_K2L;
                n_state       = S_L3;
            end
            S_L3: begin
                o_cmd.acc_op  = ACC_ADD;
                o_cmd.mul_sel = MUL_K3L;
                n_state       = S_L4;
            end
            S_L4: begin
                o_cmd.acc_op = ACC_SUB;
                n_state      = S_L5;
            end
            S_L5: begin
                o_cmd.acc_op = ACC_ZL;
                n_state      = S_R1;
            end
            S_R1: begin
                o_cmd.mul_sel = MUL_K1R;
                n_state       = S_R2;
            end
            S_R2: begin
                o_cmd.acc_op  = ACC_SET;
                o_cmd.mul_sel = MUL_K2R;
                n_state       = S_R3;
            end
            S_R3: begin
                o_cmd.acc_op  = ACC_ADD;
                o_cmd.mul_sel = MUL_K3R;
                n_state       = S_R4;
            end
            S_R4: begin
                o_cmd.acc_op = ACC_SUB;
                n_state      = S_R5;
            end
            S_R5: begin
                o_cmd.acc_op = ACC_ZR;
                n_state      = S_RES;
            end
            S_RES: begin
                if (w_slot_free) begin
                    o_cmd.acc_op = ACC_RES;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_m_axis_tready;
        if (o_cmd.acc_op == ACC_RES) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

@@ sv/dto_datapath.sv @@
`default_nettype none
module dto_datapath
    import dto_pkg::*;
#(
    parameter int SAMPLE_PERIOD_US = DEF_SAMPLE_PERIOD_US,
    parameter int FRAC_BITS        = DEF_FRAC_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DATA_W-1:0]    i_cfg_data,
    input  wire logic [DATA_W-1:0]    i_accel_estimate,
    input  wire logic [DATA_W-1:0]    i_torque_ref_rate,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    output logic [DATA_W-1:0]         o_disturbance_estimate,
    output logic                      o_saturated
);

    localparam logic [DIV_W-1:0] DIV_NUM = DIV_W'(US_PER_S) << COEF_BITS;
    localparam logic signed [PROD_W-1:0] COEF_HALF = PROD_W'(1) << (COEF_BITS - 1);
    localparam logic signed [PROD_W-1:0] FRAC_HALF = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [DATA_W:0] J_ONE = (DATA_W + 1)'(1) << FRAC_BITS;
    localparam logic signed [DATA_W:0] K_UNIT = (DATA_W + 1)'(1) << COEF_BITS;

    logic [BW_W-1:0]          r_bw;
    logic [DATA_W-1:0]        r_inertia;
    logic signed [DATA_W-1:0] r_accel, r_rate;
    logic [DATA_W-1:0]        r_s;
    logic [COEF_BITS:0]       r_rem;
    logic [DIV_W-1:0]         r_num;
    logic [DIV_CNT_W-1:0]     r_div_cnt;
    logic signed [DATA_W:0]   r_k1;
    logic [DATA_W-1:0]        r_k2;
    logic [COEF_BITS:0]       r_k3;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [DATA_W-1:0] r_tq, r_nrate;
    logic signed [DATA_W-1:0] r_lp1, r_lp2, r_rp1, r_rp2;
    logic signed [DATA_W-1:0] r_zl, r_zr;
    logic                     r_flag;
    logic [DATA_W-1:0]        r_out_data;
    logic                     r_out_sat;

    logic [DATA_W-1:0]        w_s;
    logic [DATA_W-1:0]        w_trial;
    logic                     w_ge;
    logic [COEF_BITS:0]       w_g;
    logic [PROD_W-1:0]        w_k3_wide;
    logic [COEF_BITS:0]       w_k3;
    logic [DATA_W-1:0]        w_k2;
    logic [DATA_W:0]          w_j;
    logic signed [DATA_W:0]   w_ma, w_mb;
    logic signed [PROD_W-1:0] w_prod;
    t_clip                    w_tq, w_nrate, w_z, w_res;
    logic signed [PROD_W-1:0] w_sum;

    assign w_s     = DATA_W'(US_PER_S) + DATA_W'(r_bw) * DATA_W'(SAMPLE_PERIOD_US);
    assign w_trial = {r_rem, r_num[DIV_W-1]};
    assign w_ge    = (w_trial >= r_s);
    assign w_g     = r_num[COEF_BITS:0];

    assign o_status.div_done = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

    assign w_k3_wide = r_prod + COEF_HALF;
    assign w_k3      = w_k3_wide[COEF_BITS +: COEF_BITS + 1];
    assign w_k2      = {w_g, 1'b0};
    assign w_j       = (r_inertia == '0) ? J_ONE : {1'b0, r_inertia};

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SQ: begin
                w_ma = {1'b0, 1'b0, w_g};
                w_mb = {1'b0, 1'b0, w_g};
            end
            MUL_TQ: begin
                w_ma = (DATA_W + 1)'(r_accel);
                w_mb = w_j;
            end
            MUL_K1L: begin
                w_ma = r_k1;
                w_mb = (DATA_W + 1)'(r_tq);
            end
            MUL_K2L: begin
                w_ma = {1'b0, r_k2};
                w_mb = (DATA_W + 1)'(r_lp1);
            end
            MUL_K3L: begin
                w_ma = {1'b0, 1'b0, r_k3};
                w_mb = (DATA_W + 1)'(r_lp2);
            end
            MUL_K1R: begin
                w_ma = r_k1;
                w_mb = (DATA_W + 1)'(r_nrate);
            end
            MUL_K2R: begin
                w_ma = {1'b0, r_k2};
                w_mb = (DATA_W + 1)'(r_rp1);
            end
            MUL_K3R: begin
                w_ma = {1'b0, 1'b0, r_k3};
                w_mb = (DATA_W + 1)'(r_rp2);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod  = w_ma * w_mb;
    assign w_tq    = clip32((r_prod + FRAC_HALF) >>> FRAC_BITS);
    assign w_nrate = clip32(-PROD_W'(r_rate));
    assign w_z     = clip32((r_acc + COEF_HALF) >>> COEF_BITS);
    assign w_sum   = PROD_W'(r_zl) + PROD_W'(r_zr);
    assign w_res   = clip32(-w_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw      <= BW_RESET;
            r_inertia <= INERTIA_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BANDWIDTH: r_bw      <= i_cfg_data[BW_W-1:0];
                REG_INERTIA:   r_inertia <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp1  <= '0;
            r_lp2  <= '0;
            r_rp1  <= '0;
            r_rp2  <= '0;
            r_flag <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_flag <= 1'b0;
            end
            case (i_cmd.acc_op)
                ACC_TQ: r_flag <= r_flag | w_tq.sat | w_nrate.sat;
                ACC_ZL: begin
                    r_flag <= r_flag | w_z.sat;
                    r_lp2  <= r_lp1;
                    r_lp1  <= w_z.value;
                end
                ACC_ZR: begin
                    r_flag <= r_flag | w_z.sat;
                    r_rp2  <= r_rp1;
                    r_rp1  <= w_z.value;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_cmd.load) begin
            r_accel   <= i_accel_estimate;
            r_rate    <= i_torque_ref_rate;
            r_s       <= w_s;
            r_num     <= DIV_NUM + DIV_W'(w_s >> 1);
            r_rem     <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= w_ge ? (COEF_BITS + 1)'(w_trial - r_s) : w_trial[COEF_BITS:0];
            r_num     <= {r_num[DIV_W-2:0], w_ge};
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
        case (i_cmd.acc_op)
            ACC_K: begin
                r_k3 <= w_k3;
                r_k2 <= w_k2;
                r_k1 <= K_UNIT - $signed({1'b0, w_k2}) + $signed({2'b00, w_k3[COEF_BITS-1:0]})
                        + $signed((DATA_W + 1)'({w_k3[COEF_BITS], {COEF_BITS{1'b0}}}));
            end
            ACC_TQ: begin
                r_tq    <= w_tq.value;
                r_nrate <= w_nrate.value;
            end
            ACC_SET: r_acc <= r_prod;
            ACC_ADD: r_acc <= r_acc + r_prod;
            ACC_SUB: r_acc <= r_acc - r_prod;
            ACC_ZL:  r_zl  <= w_z.value;
            ACC_ZR:  r_zr  <= w_z.value;
            ACC_RES: begin
                r_out_data <= w_res.value;
                r_out_sat  <= r_flag | w_res.sat;
            end
            default: begin
            end
        endcase
    end

    assign o_disturbance_estimate = r_out_data;
    assign o_saturated            = r_out_sat;

endmodule
`default_nettype wire

@@ sv/disturbance_torque_observer.sv @@
// Result tvalid rises once the divide and multiply steps for an item are done.
// Items run one at a time; the 50-step serial divide for the filter gain and
// the one shared 33x33 multiplier, used eight times, set the pace.
// A finished result waits in the output register while the next item runs.
// Reset (synchronous, active low) clears filter history and output valid and
// restores bandwidth 100 and inertia 1.0.
`default_nettype none
module disturbance_torque_observer
    import dto_pkg::*;
#(
    parameter int SAMPLE_PERIOD_US = DEF_SAMPLE_PERIOD_US,
    parameter int FRAC_BITS        = DEF_FRAC_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DATA_W-1:0]    i_cfg_data,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // [31:0] accel_estimate, [63:32] torque_ref_rate
    input  wire logic [2*DATA_W-1:0]  i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // [31:0] disturbance_estimate
    output logic [DATA_W-1:0]         o_m_axis_tdata,
    // [0] saturated
    output logic [0:0]                o_m_axis_tuser
);

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    dto_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_status        (w_status),
        .o_cmd           (w_cmd)
    );

    dto_datapath #(
        .SAMPLE_PERIOD_US (SAMPLE_PERIOD_US),
        .FRAC_BITS        (FRAC_BITS)
    ) u_datapath (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_valid            (i_cfg_valid),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_accel_estimate       (i_s_axis_tdata[DATA_W-1:0]),
        .i_torque_ref_rate      (i_s_axis_tdata[2*DATA_W-1:DATA_W]),
        .i_cmd                  (w_cmd),
        .o_status               (w_status),
        .o_disturbance_estimate (o_m_axis_tdata),
        .o_saturated            (o_m_axis_tuser[0])
    );

endmodule
`default_nettype wire

@@ sv/dto_checker.sv @@
`default_nettype none
module dto_checker
    import dto_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_s_axis_tvalid,
    input wire logic                o_s_axis_tready,
    input wire logic                o_m_axis_tvalid,
    input wire logic                i_m_axis_tready,
    input wire logic [DATA_W-1:0]   o_m_axis_tdata,
    input wire logic [0:0]          o_m_axis_tuser
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after transfer");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready))
        else $error("result appeared without a running item");

endmodule

bind disturbance_torque_observer dto_checker u_dto_checker (.*);
`default_nettype wire

@@ test/disturbance_torque_observer_tb.sv @@
`timescale 1ns / 1ps

module disturbance_torque_observer_tb;
    import dto_pkg::*;

    localparam int IDLE_PCT       = 69;
    localparam int BOTH_PCT       = 17;
    localparam int SETTLE_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 141;
    localparam int REPORT_LIMIT   = 10;

    localparam logic signed [79:0] SAT_HI = 80'sh7FFF_FFFF;
    localparam logic signed [79:0] SAT_LO = -80'sh8000_0000;

    typedef enum int {
        TRAFFIC_FREE,
        TRAFFIC_SRC_IDLE,
        TRAFFIC_SINK_STALL,
        TRAFFIC_BOTH
    } traffic_t;

    typedef struct packed {
        logic [DATA_W-1:0] estimate;
        logic              saturated;
    } estimate_t;

    class observer_scoreboard;
        logic [BW_W-1:0]          bandwidth;
        logic [DATA_W-1:0]        inertia;
        logic signed [DATA_W-1:0] load_z1;
        logic signed [DATA_W-1:0] load_z2;
        logic signed [DATA_W-1:0] ref_z1;
        logic signed [DATA_W-1:0] ref_z2;
        logic signed [79:0]       gain1;
        logic signed [79:0]       gain2;
        logic signed [79:0]       gain3;
        bit                       step_sat;
        int                       mismatches;
        estimate_t                expected_estimates[$];

        function new();
            bandwidth  = BW_RESET;
            inertia    = INERTIA_RESET;
            load_z1    = '0;
            load_z2    = '0;
            ref_z1     = '0;
            ref_z2     = '0;
            step_sat   = 1'b0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_estimates.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            if (idx == REG_BANDWIDTH)
                bandwidth = data[BW_W-1:0];
            else if (idx == REG_INERTIA)
                inertia = data;
        endfunction

        function logic signed [DATA_W-1:0] clamp32(logic signed [79:0] v);
            if (v > SAT_HI) begin
                step_sat = 1'b1;
                return SAT_HI[DATA_W-1:0];
            end
            if (v < SAT_LO) begin
                step_sat = 1'b1;
                return SAT_LO[DATA_W-1:0];
            end
            return v[DATA_W-1:0];
        endfunction

        function void update_gains();
            logic [63:0] s;
            logic [63:0] g;
            logic [63:0] g_sq;
            s = 64'(US_PER_S) + 64'(bandwidth) * 64'(DEF_SAMPLE_PERIOD_US);
            g = ((64'(US_PER_S) << COEF_BITS) + s / 2) / s;
            g_sq = (g * g + (64'd1 << (COEF_BITS - 1))) >> COEF_BITS;
            gain2 = $signed({16'd0, g << 1});
            gain3 = $signed({16'd0, g_sq});
            gain1 = (80'sd1 <<< COEF_BITS) - gain2 + gain3;
        endfunction

        function logic signed [DATA_W-1:0] filter_out(logic signed [DATA_W-1:0] x,
                                                      logic signed [DATA_W-1:0] z1,
                                                      logic signed [DATA_W-1:0] z2);
            logic signed [79:0] acc;
            acc = gain1 * 80'(x) + gain2 * 80'(z1) - gain3 * 80'(z2);
            acc = (acc + (80'sd1 <<< (COEF_BITS - 1))) >>> COEF_BITS;
            return clamp32(acc);
        endfunction

        function void predict_step(logic signed [DATA_W-1:0] accel,
                                   logic signed [DATA_W-1:0] rate);
            logic signed [79:0]       wide;
            logic signed [79:0]       scale;
            logic signed [DATA_W-1:0] torque;
            logic signed [DATA_W-1:0] neg_rate;
            logic signed [DATA_W-1:0] z_load;
            logic signed [DATA_W-1:0] z_ref;
            estimate_t                e;
            step_sat = 1'b0;
            update_gains();
            scale = (inertia == '0) ? (80'sd1 <<< DEF_FRAC_BITS) : $signed({48'd0, inertia});
            wide = 80'(accel);
            wide = wide * scale;
            wide = (wide + (80'sd1 <<< (DEF_FRAC_BITS - 1))) >>> DEF_FRAC_BITS;
            torque = clamp32(wide);
            wide = 80'(rate);
            neg_rate = clamp32(-wide);
            z_load = filter_out(torque, load_z1, load_z2);
            load_z2 = load_z1;
            load_z1 = z_load;
            z_ref = filter_out(neg_rate, ref_z1, ref_z2);
            ref_z2 = ref_z1;
            ref_z1 = z_ref;
            wide = 80'(z_load);
            wide = -(wide + 80'(z_ref));
            e.estimate  = clamp32(wide);
            e.saturated = step_sat;
            expected_estimates.push_back(e);
        endfunction

        function void flag_error(string what);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%s", what);
        endfunction

        function void check_estimate(logic [DATA_W-1:0] estimate, logic saturated);
            estimate_t e;
            if (expected_estimates.size() == 0) begin
                flag_error($sformatf("unexpected result: estimate %h sat %0d",
                                     estimate, saturated));
                return;
            end
            e = expected_estimates.pop_front();
            if (e.estimate !== estimate || e.saturated !== saturated)
                flag_error($sformatf("mismatch: expected estimate %h sat %0d, got %h sat %0d",
                                     e.estimate, e.saturated, estimate, saturated));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [DATA_W-1:0]     cfg_data;
    logic                  s_tvalid;
    logic [2*DATA_W-1:0]   s_tdata;
    logic                  m_tready;
    logic                  o_cfg_ready;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [DATA_W-1:0]     o_m_axis_tdata;
    logic [0:0]            o_m_axis_tuser;

    observer_scoreboard    sb;
    int                    src_idle_pct;
    int                    sink_stall_pct;
    int unsigned           quiet_cycles;

    disturbance_torque_observer u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && o_cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && o_s_axis_tready)
                sb.predict_step(s_tdata[DATA_W-1:0], s_tdata[2*DATA_W-1:DATA_W]);
            if (o_m_axis_tvalid && m_tready)
                sb.check_estimate(o_m_axis_tdata, o_m_axis_tuser[0]);
        end
    end

    always @(posedge clk) begin
        if ((cfg_valid && o_cfg_ready) || (s_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_traffic(traffic_t mode);
        case (mode)
            TRAFFIC_FREE: begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            TRAFFIC_SRC_IDLE: begin
                src_idle_pct   = IDLE_PCT;
                sink_stall_pct = 0;
            end
            TRAFFIC_SINK_STALL: begin
                src_idle_pct   = 0;
                sink_stall_pct = IDLE_PCT;
            end
            default: begin
                src_idle_pct   = BOTH_PCT;
                sink_stall_pct = BOTH_PCT;
            end
        endcase
    endtask

    task automatic send_item(logic [DATA_W-1:0] accel, logic [DATA_W-1:0] rate);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rate, accel};
        @(posedge clk);
        while (!o_s_axis_tready)
            @(posedge clk);
    endtask

    // drop valid, let all results arrive, then let the block settle
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!o_cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_bandwidth(logic [BW_W-1:0] bw);
        logic [DATA_W-1:0] w;
        w = $urandom();
        w[BW_W-1:0] = bw;
        write_reg(REG_BANDWIDTH, w);
    endtask

    function automatic logic [DATA_W-1:0] rand_signal();
        logic [DATA_W-1:0] v;
        case ($urandom_range(9))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = '0;
            3, 4, 5: v = $urandom_range(32'h0010_0000) - 32'h0008_0000;
            6, 7:    v = $urandom_range(32'h0800_0000) - 32'h0400_0000;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    function automatic logic [BW_W-1:0] pick_bandwidth(int phase);
        case (phase)
            0: return '0;
            1: return '1;
            2: return 14'd10000;
            3: return 14'd1;
            default: begin
                if ($urandom_range(1) == 0)
                    return BW_W'($urandom_range(10000));
                return BW_W'($urandom());
            end
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_inertia(int phase);
        case (phase)
            0: return '0;
            1: return '1;
            2: return 32'd65536;
            3: return 32'd1;
            default: begin
                if ($urandom_range(1) == 0)
                    return $urandom_range(32'h0010_0000, 1);
                return $urandom();
            end
        endcase
    endfunction

    initial begin
        int                n;
        int                run;
        bit                hold;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] r;
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_BANDWIDTH;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        quiet_cycles = 0;
        sb = new();
        set_traffic(TRAFFIC_FREE);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: field extremes, most negative rate
        send_item(32'h0000_0000, 32'h0000_0000);
        send_item(32'h7FFF_FFFF, 32'h0000_0000);
        send_item(32'h8000_0000, 32'h0000_0000);
        send_item(32'h0000_0000, 32'h8000_0000);
        send_item(32'h0000_0000, 32'h7FFF_FFFF);
        send_item(32'h8000_0000, 32'h8000_0000);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(32'h0000_0001, 32'hFFFF_FFFF);
        drain();

        // zero inertia as unity, zero bandwidth drops the input gain
        write_reg(REG_INERTIA, 32'd0);
        write_bandwidth(14'd0);
        send_item(32'h0000_3039, 32'hFFFF_2B4F);
        send_item(32'h0001_0000, 32'h0001_0000);
        send_item(32'hFFFF_FFFF, 32'h0000_0001);
        send_item(32'h0000_0000, 32'h0000_0000);
        drain();

        // bandwidth above the nominal range, largest inertia
        write_bandwidth(14'h3FFF);
        write_reg(REG_INERTIA, 32'hFFFF_FFFF);
        send_item(32'h7FFF_FFFF, 32'h8000_0000);
        send_item(32'h8000_0000, 32'h7FFF_FFFF);
        send_item(32'h0000_0001, 32'hFFFF_FFFF);
        send_item(32'h0000_0000, 32'h0000_0000);
        drain();

        write_bandwidth(14'd10000);
        write_reg(REG_INERTIA, 32'd65536);
        send_item(32'h0002_0000, 32'hFFFE_0000);
        send_item(32'h0002_0000, 32'hFFFE_0000);
        send_item(32'hFFF0_0000, 32'h0010_0000);
        send_item(32'h0000_0000, 32'h0000_0000);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            set_traffic(traffic_t'(p % 4));
            if ($urandom_range(1) == 0) begin
                write_bandwidth(pick_bandwidth(p));
                write_reg(REG_INERTIA, pick_inertia(p));
            end else begin
                write_reg(REG_INERTIA, pick_inertia(p));
                write_bandwidth(pick_bandwidth(p));
            end
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                run  = $urandom_range(24, 1);
                hold = ($urandom_range(3) == 0);
                a = rand_signal();
                r = rand_signal();
                for (int k = 0; k < run && n < ITEMS_PER_PHASE; k++) begin
                    if (!hold) begin
                        a = rand_signal();
                        r = rand_signal();
                    end
                    send_item(a, r);
                    n++;
                end
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
